// ----- hdl/lpfd_pkg.sv -----
// Types and constants shared by the length-prefixed frame deframer.
// No dependencies.
package lpfd_pkg;

	localparam int unsigned HDR_BYTES = 12;
	localparam int unsigned META_LEN_BYTES = 4;
	localparam logic [3:0] HDR_LAST = 4'(HDR_BYTES - 1);

	localparam logic CFG_SENTINEL = 1'b0;
	localparam logic CFG_MAX_META = 1'b1;

	localparam logic [7:0] SENTINEL_RST = 8'd0;
	localparam logic [31:0] MAX_META_RST = 32'd65536;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_META    = 3'd1,
		PH_START   = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_END     = 3'd4
	} phase_t;

	typedef enum logic [3:0] {
		ST_CONSUMED   = 4'd0,
		ST_DATA       = 4'd1,
		ST_HEADER     = 4'd2,
		ST_FRAME      = 4'd3,
		ST_EOS        = 4'd4,
		ST_EOF        = 4'd5,
		ST_INCOMPLETE = 4'd6,
		ST_META_LONG  = 4'd7,
		ST_BAD_START  = 4'd8,
		ST_BAD_END    = 4'd9
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_kind;
		logic        last_in_section;
		status_t     status;
		logic [31:0] meta_length;
		logic [63:0] payload_length;
	} out_item_t;

endpackage

// ----- hdl/lpfd_in_stage.sv -----
// Input register stage of the deframer: holds one accepted item.
// Depends on lpfd_pkg.
module lpfd_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             ready,
	input  lpfd_pkg::in_item_t item,
	output logic             item_valid,
	input  logic             item_ready,
	output lpfd_pkg::in_item_t item_s1
);
	import lpfd_pkg::*;

	logic valid_s1;

	assign ready = !valid_s1 || item_ready;
	assign item_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (valid && ready) begin
			item_s1 <= item;
		end
	end

endmodule

// ----- hdl/lpfd_parser.sv -----
// Frame parser: configuration registers, parse state and next-result logic.
// Depends on lpfd_pkg.
module lpfd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                item_valid,
	output logic                item_ready,
	input  lpfd_pkg::in_item_t  item,
	output logic                res_valid,
	input  logic                res_ready,
	output lpfd_pkg::out_item_t res
);
	import lpfd_pkg::*;

	logic [7:0]  sentinel_q;
	logic [31:0] max_meta_q;

	phase_t      phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [31:0] meta_q, meta_d, meta_acc;
	logic [63:0] pay_q, pay_d, pay_acc;
	logic [63:0] left_q, left_d, left_dec;
	logic        done_q, done_d;
	logic        fire;

	assign cfg_ready = 1'b1;
	assign item_ready = res_ready;
	assign res_valid = item_valid;
	assign fire = item_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sentinel_q <= SENTINEL_RST;
			max_meta_q <= MAX_META_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SENTINEL: sentinel_q <= cfg_data[7:0];
				CFG_MAX_META: max_meta_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		meta_acc = (cnt_q == 4'd0) ? '0 : meta_q;
		pay_acc = (cnt_q == 4'd0) ? '0 : pay_q;
		for (int i = 0; i < META_LEN_BYTES; i++) begin
			if (cnt_q == 4'(i)) begin
				meta_acc[8*i +: 8] = item.in_byte;
			end
		end
		for (int i = 0; i < HDR_BYTES - META_LEN_BYTES; i++) begin
			if (cnt_q == 4'(i + META_LEN_BYTES)) begin
				pay_acc[8*i +: 8] = item.in_byte;
			end
		end
		left_dec = left_q - 64'(left_q != '0);
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		meta_d = meta_q;
		pay_d = pay_q;
		left_d = left_q;
		done_d = done_q;
		res = '0;
		res.status = ST_CONSUMED;
		if (done_q) begin
			res.status = ST_EOF;
		end else if (item.stream_end) begin
			if (phase_q == PH_HEADER && cnt_q == 4'd0) begin
				done_d = 1'b1;
				res.status = ST_EOF;
			end else begin
				res.status = ST_INCOMPLETE;
				phase_d = PH_HEADER;
				cnt_d = '0;
				left_d = '0;
			end
		end else begin
			case (phase_q)
				PH_HEADER: begin
					meta_d = meta_acc;
					pay_d = pay_acc;
					if (cnt_q != HDR_LAST) begin
						cnt_d = cnt_q + 4'd1;
					end else begin
						cnt_d = '0;
						if (meta_acc == '0 && pay_acc == '0) begin
							done_d = 1'b1;
							res.status = ST_EOS;
						end else if (meta_acc > max_meta_q) begin
							res.status = ST_META_LONG;
							left_d = '0;
						end else begin
							res.status = ST_HEADER;
							res.meta_length = meta_acc;
							res.payload_length = pay_acc;
							left_d = 64'(meta_acc);
							phase_d = (meta_acc != '0) ? PH_META : PH_START;
						end
					end
				end
				PH_META, PH_PAYLOAD: begin
					res.status = ST_DATA;
					res.out_byte = item.in_byte;
					res.byte_kind = (phase_q == PH_PAYLOAD);
					res.last_in_section = (left_dec == '0);
					left_d = left_dec;
					if (left_dec == '0) begin
						phase_d = (phase_q == PH_META) ? PH_START : PH_END;
					end
				end
				PH_START: begin
					if (item.in_byte == sentinel_q) begin
						left_d = pay_q;
						phase_d = (pay_q != '0) ? PH_PAYLOAD : PH_END;
					end else begin
						res.status = ST_BAD_START;
						phase_d = PH_HEADER;
						cnt_d = '0;
						left_d = '0;
					end
				end
				PH_END: begin
					res.status = (item.in_byte == sentinel_q) ? ST_FRAME : ST_BAD_END;
					phase_d = PH_HEADER;
					cnt_d = '0;
					left_d = '0;
				end
				default: begin
					phase_d = PH_HEADER;
					cnt_d = '0;
					left_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q <= '0;
			meta_q <= '0;
			pay_q <= '0;
			left_q <= '0;
			done_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			meta_q <= meta_d;
			pay_q <= pay_d;
			left_q <= left_d;
			done_q <= done_d;
		end
	end

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q)
		else $error("end of stream flag cleared");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (phase_q == PH_HEADER && cnt_q == 4'd0))
		else $error("end of stream seen outside a header boundary");

	a_section_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_META || phase_q == PH_PAYLOAD) |-> (left_q != '0))
		else $error("data section with no bytes left");

	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 4'd0) |-> (phase_q == PH_HEADER && cnt_q <= HDR_LAST))
		else $error("header byte count out of range");

endmodule

// ----- hdl/lpfd_out_stage.sv -----
// Result register stage of the deframer: holds one result until taken.
// Depends on lpfd_pkg.
module lpfd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	output logic                res_ready,
	input  lpfd_pkg::out_item_t res,
	output logic                valid,
	input  logic                ready,
	output lpfd_pkg::out_item_t item
);
	import lpfd_pkg::*;

	logic valid_s2;

	assign res_ready = !valid_s2 || ready;
	assign valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_ready) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			item <= res;
		end
	end

endmodule

// ----- hdl/length_prefixed_frame_deframer_unit.sv -----
// Top level of the length-prefixed frame deframer.
// Depends on lpfd_pkg, lpfd_in_stage, lpfd_parser and lpfd_out_stage.
//
// Usage:
//   in_*   : one stream byte (or a stream-end flag) per item, valid/ready.
//   out_*  : exactly one result item per input item, in order, valid/ready.
//   cfg_*  : register writes; index 0 sets the sentinel byte, index 1 the
//            largest metadata length. cfg_ready is always high. Write only
//            while no item is in flight.
// Path: an accepted item passes the input register, then the result
//   register, where it is held until taken.
// Throughput: one item per cycle while out_ready is high; the parse state
//   update is a single registered step, with the 64-bit section counter
//   decrement as the longest path.
// Reset: arst_n clears both stages, returns the parser to waiting for a
//   header, clears end of stream, and restores sentinel 0 and a 65536-byte
//   metadata limit.
// Stall: when out_ready is low, a full result register holds, the input
//   register keeps or takes at most one more item, and in_ready stays low
//   until the result is taken.
module length_prefixed_frame_deframer_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lpfd_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output lpfd_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data
);
	import lpfd_pkg::*;

	in_item_t  item_s1;
	logic      item_valid;
	logic      item_ready;
	out_item_t res;
	logic      res_valid;
	logic      res_ready;

	lpfd_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (in_valid),
		.ready      (in_ready),
		.item       (in_item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_s1    (item_s1)
	);

	lpfd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item_s1),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	lpfd_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.valid     (out_valid),
		.ready     (out_ready),
		.item      (out_item)
	);

endmodule
